// File: src/matrix_vector_product_defines.svh
// ----------------------------------------------------------------------------
// matrix_vector_product_defines
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef MATRIX_VECTOR_PRODUCT_DEFINES_SVH
`define MATRIX_VECTOR_PRODUCT_DEFINES_SVH

// concurrent assertion on clk_i, off while rst_ni is low
`define MVP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication form: antecedent holds, consequent follows in the next cycle
`define MVP_ASSERT_NEXT(lbl, ante, cons, msg) \
  `MVP_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// File: src/mvp_pkg.sv
// ----------------------------------------------------------------------------
// mvp_pkg
// types and constants of the matrix vector product engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mvp_pkg;

  localparam int MAX_DIM    = 16;
  localparam int VALUE_BITS = 16;

  localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CNT_W  = $clog2(MAX_DIM + 1);
  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PROD_W = 2 * VALUE_BITS;
  localparam int SUM_W  = 40;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  // input item kinds
  localparam logic [1:0] KIND_MATRIX  = 2'd0;
  localparam logic [1:0] KIND_VECTOR  = 2'd1;
  localparam logic [1:0] KIND_COMPUTE = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic [3:0]         row_index;
    logic [3:0]         col_index;
    logic [3:0]         vector_index;
    logic signed [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum_value;
    logic [3:0]              result_index;
    logic                    last;
  } out_item_t;

endpackage

`default_nettype wire

// File: src/mvp_ram.sv
// ----------------------------------------------------------------------------
// mvp_ram
// simple dual port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mvp_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 16
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                         wdata_i,
  input  wire logic                                     re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output      logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: src/matrix_vector_product.sv
// ----------------------------------------------------------------------------
// matrix_vector_product
// matrix times vector and vector times matrix over one shared multiply-accumulate
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | input     | in_valid_i/in_stall_o | in_data_i  (in_item_t)
//  out     | output    | out_valid_o/out_stall_i | out_data_o (out_item_t)
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
//  a matrix or vector load item is accepted whenever the block is idle, loads may follow back to back
//  a compute item issues one multiply-accumulate per cycle through the matrix ram
//  read port, inner times per sum; each sum passes ram read, multiply, accumulate and
//  output load, inner being the column count or the row count by direction
//  in_stall_o stays high from the compute transfer until the last sum is loaded;
//  a stalled output holds the sequencer before the next sum is loaded
//  reset clears control and configuration only, the stores are not cleared
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module matrix_vector_product import mvp_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output      logic                  in_stall_o,
  input  wire in_item_t              in_data_i,
  output      logic                  out_valid_o,
  input  wire logic                  out_stall_i,
  output      out_item_t             out_data_o,
  input  wire logic                  cfg_valid_i,
  output      logic                  cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  state_e state_q;

  logic [CFG_DATA_W-1:0] row_cnt_q, col_cnt_q;
  logic                  dir_q;

  logic [CNT_W-1:0] rows, cols, outer_cnt, inner_cnt;
  logic [IDX_W-1:0] i_q, j_q;
  logic             i_last, j_last;

  logic             in_fire;
  logic [IDX_W-1:0] wr_row, wr_col, wr_vec;
  logic             mat_we;
  logic [ADDR_W-1:0] mat_waddr, mat_raddr;
  logic [IDX_W-1:0] rd_row, rd_col;
  logic             issue;

  logic [VALUE_BITS-1:0] vec_q [MAX_DIM];
  logic [VALUE_BITS-1:0] mat_rdata;

  logic                         v1_q, first1_q, last1_q;
  logic signed [VALUE_BITS-1:0] vec1_q;
  logic                         v2_q, first2_q, last2_q;
  logic signed [PROD_W-1:0]     prod_q;
  logic signed [SUM_W-1:0]      acc_q;

  logic      out_valid_q;
  out_item_t out_data_q;

  function automatic logic [CNT_W-1:0] clamp_count(input logic [CFG_DATA_W-1:0] c);
    logic [CNT_W-1:0] r;
    if (c == '0) begin
      r = CNT_W'(1);
    end else if (int'(c) > MAX_DIM) begin
      r = CNT_W'(MAX_DIM);
    end else begin
      r = CNT_W'(c);
    end
    return r;
  endfunction

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt_q <= CFG_DATA_W'(1);
      col_cnt_q <= CFG_DATA_W'(1);
      dir_q     <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_ROW_COUNT: row_cnt_q <= cfg_data_i;
        CFG_COL_COUNT: col_cnt_q <= cfg_data_i;
        CFG_DIRECTION: dir_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign rows      = clamp_count(row_cnt_q);
  assign cols      = clamp_count(col_cnt_q);
  assign outer_cnt = dir_q ? cols : rows;
  assign inner_cnt = dir_q ? rows : cols;

  assign i_last = (CNT_W'(i_q) + 1'b1) == outer_cnt;
  assign j_last = (CNT_W'(j_q) + 1'b1) == inner_cnt;

  // loads
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;

  assign wr_row = IDX_W'(in_data_i.row_index);
  assign wr_col = IDX_W'(in_data_i.col_index);
  assign wr_vec = IDX_W'(in_data_i.vector_index);

  assign mat_we = in_fire && (in_data_i.kind == KIND_MATRIX)
                  && (int'(in_data_i.row_index) < MAX_DIM)
                  && (int'(in_data_i.col_index) < MAX_DIM);
  assign mat_waddr = ADDR_W'(int'(wr_row) * MAX_DIM + int'(wr_col));

  always_ff @(posedge clk_i) begin
    if (in_fire && (in_data_i.kind == KIND_VECTOR)
        && (int'(in_data_i.vector_index) < MAX_DIM)) begin
      vec_q[wr_vec] <= VALUE_BITS'($unsigned(in_data_i.value));
    end
  end

  // issue stage: direction picks which counter walks the rows
  assign issue     = (state_q == ST_ISSUE);
  assign rd_row    = dir_q ? j_q : i_q;
  assign rd_col    = dir_q ? i_q : j_q;
  assign mat_raddr = ADDR_W'(int'(rd_row) * MAX_DIM + int'(rd_col));

  mvp_ram #(
    .DEPTH(DEPTH),
    .WIDTH(VALUE_BITS)
  ) u_mat_ram (
    .clk_i  (clk_i),
    .we_i   (mat_we),
    .waddr_i(mat_waddr),
    .wdata_i(VALUE_BITS'($unsigned(in_data_i.value))),
    .re_i   (issue),
    .raddr_i(mat_raddr),
    .rdata_o(mat_rdata)
  );

  // multiply-accumulate pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= issue;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    first1_q <= (j_q == '0);
    last1_q  <= j_last;
    vec1_q   <= vec_q[j_q];
    first2_q <= first1_q;
    last2_q  <= last1_q;
    prod_q   <= $signed(mat_rdata) * vec1_q;
    if (v2_q) begin
      acc_q <= (first2_q ? SUM_W'(0) : acc_q) + SUM_W'(prod_q);
    end
  end

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      i_q         <= '0;
      j_q         <= '0;
    end else begin
      // in ST_EMIT the load below decides the valid bit
      if (out_valid_q && !out_stall_i && (state_q != ST_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire && (in_data_i.kind == KIND_COMPUTE)) begin
            i_q     <= '0;
            j_q     <= '0;
            state_q <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          if (j_last) begin
            j_q     <= '0;
            state_q <= ST_DRAIN;
          end else begin
            j_q <= j_q + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (v2_q && last2_q) begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          // load once the previous sum has left or leaves now
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q             <= 1'b1;
            out_data_q.sum_value    <= acc_q;
            out_data_q.result_index <= 4'(i_q);
            out_data_q.last         <= i_last;
            if (i_last) begin
              state_q <= ST_IDLE;
            end else begin
              i_q     <= i_q + 1'b1;
              state_q <= ST_ISSUE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// File: src/mvp_checker.sv
// ----------------------------------------------------------------------------
// mvp_checker
// port level checks of the matrix vector product engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "matrix_vector_product_defines.svh"

module mvp_checker import mvp_pkg::*; (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  in_valid_i,
  input wire logic                  in_stall_o,
  input wire in_item_t              in_data_i,
  input wire logic                  out_valid_o,
  input wire logic                  out_stall_i,
  input wire out_item_t             out_data_o,
  input wire logic                  cfg_valid_i,
  input wire logic                  cfg_ready_o,
  input wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic in_xfer, cfg_xfer;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign cfg_xfer = cfg_valid_i && cfg_ready_o;

  // a stalled result holds
  `MVP_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
                   out_valid_o && $stable(out_data_o), "stalled result changed")

  // a compute transfer blocks the input channel
  `MVP_ASSERT_NEXT(a_compute_busy, in_xfer && (in_data_i.kind == KIND_COMPUTE),
                   in_stall_o, "input not stalled after compute transfer")

  // load and unused items never start a run
  `MVP_ASSERT_NEXT(a_load_quiet, in_xfer && (in_data_i.kind != KIND_COMPUTE),
                   !in_stall_o, "input stalled after load transfer")

  // results appear only while a run holds the input channel
  `MVP_ASSERT(a_out_from_run, $rose(out_valid_o) |-> $past(in_stall_o),
              "result without a running compute")

  // register writes carry a known index and data
  `MVP_ASSERT(a_cfg_known, cfg_xfer |-> !$isunknown({cfg_index_i, cfg_data_i}),
              "unknown register write")

endmodule

bind matrix_vector_product mvp_checker u_mvp_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o),
  .cfg_valid_i(cfg_valid_i),
  .cfg_ready_o(cfg_ready_o),
  .cfg_index_i(cfg_index_i),
  .cfg_data_i (cfg_data_i)
);

`default_nettype wire

// File: tb/matrix_vector_product_tb.sv
// ----------------------------------------------------------------------------
// matrix_vector_product_tb
// checks matrix times vector and vector times matrix sums against a local
// predictor; loads and computes are streamed under random idling and stalls
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module matrix_vector_product_tb;
  import mvp_pkg::*;

  localparam int ITEM_TARGET    = 460;
  localparam int SETTLE_CYCLES  = 8;
  localparam int END_CYCLES     = 32;
  localparam int LONG_HOLD      = 150;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int REPORT_LIMIT   = 10;

  // register index that the block does not implement
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [1:0]           KIND_NONE  = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  matrix_vector_product i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #2ns clk_i = ~clk_i;

  // predictor state
  logic signed [VALUE_BITS-1:0] matrix_copy [MAX_DIM][MAX_DIM];
  logic signed [VALUE_BITS-1:0] vector_copy [MAX_DIM];
  logic [4:0] rows_reg = 5'd1;
  logic [4:0] cols_reg = 5'd1;
  logic       dir_reg  = 1'b0;

  out_item_t expected_sums [$];
  in_item_t  pending_items [$];

  // generator view: which entries hold data, and the active shape
  bit matrix_written [MAX_DIM][MAX_DIM];
  bit vector_written [MAX_DIM];
  int gen_rows = 1;
  int gen_cols = 1;
  bit gen_dir  = 1'b0;

  int  items_queued   = 0;
  int  items_accepted = 0;
  int  computes_seen  = 0;
  int  sums_checked   = 0;
  int  cfg_writes     = 0;
  int  mismatches     = 0;
  int  idle_cycles    = 0;
  int  hold_requests  = 0;
  int  hold_seen      = 0;
  int  hold_left      = 0;
  logic in_fire = 1'b0;

  function automatic int clamp_dim(logic [4:0] raw);
    if (raw == 0) return 1;
    if (raw > MAX_DIM) return MAX_DIM;
    return int'(raw);
  endfunction

  function automatic bit roll(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // first third: sender 13 / receiver 50, then swapped, then no idling
  function automatic int sender_idle_pct();
    if (items_accepted < 150) return 13;
    if (items_accepted < 300) return 50;
    return 0;
  endfunction

  function automatic int receiver_idle_pct();
    if (items_accepted < 150) return 50;
    if (items_accepted < 300) return 13;
    return 0;
  endfunction

  task automatic apply_item(in_item_t it);
    int outer;
    int inner;
    logic signed [PROD_W-1:0] prod;
    logic signed [SUM_W-1:0]  acc;
    out_item_t want;
    case (it.kind)
      KIND_MATRIX: matrix_copy[it.row_index][it.col_index] = it.value;
      KIND_VECTOR: vector_copy[it.vector_index] = it.value;
      KIND_COMPUTE: begin
        outer = dir_reg ? clamp_dim(cols_reg) : clamp_dim(rows_reg);
        inner = dir_reg ? clamp_dim(rows_reg) : clamp_dim(cols_reg);
        for (int i = 0; i < outer; i++) begin
          acc = '0;
          for (int j = 0; j < inner; j++) begin
            if (!dir_reg) prod = matrix_copy[i][j] * vector_copy[j];
            else prod = vector_copy[j] * matrix_copy[j][i];
            acc = acc + prod;
          end
          want.sum_value    = acc;
          want.result_index = 4'(i);
          want.last         = (i == outer - 1);
          expected_sums = {expected_sums, want};
        end
        computes_seen++;
      end
      default: ;
    endcase
  endtask

  task automatic check_sum(out_item_t got);
    out_item_t want;
    if (expected_sums.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("%0t: unexpected sum: index %0d value %0d last %0b", $realtime,
                 got.result_index, got.sum_value, got.last);
    end else begin
      want = expected_sums.pop_front();
      sums_checked++;
      if (got.sum_value !== want.sum_value || got.result_index !== want.result_index ||
          got.last !== want.last) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("%0t: sum mismatch: expected index %0d value %0d last %0b",
                   $realtime, want.result_index, want.sum_value, want.last);
          $display("%0t:                    got index %0d value %0d last %0b",
                   $realtime, got.result_index, got.sum_value, got.last);
        end
      end
    end
  endtask

  // sampling at the rising edge: results, input transfers, register writes
  always @(posedge clk_i) begin
    in_fire <= rst_ni && in_valid && !in_stall;
    if (rst_ni) begin
      if (out_valid && !out_stall) check_sum(out_data);
      if (in_valid && !in_stall) begin
        apply_item(in_data);
        items_accepted++;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ROW_COUNT: rows_reg = cfg_data;
          CFG_COL_COUNT: cols_reg = cfg_data;
          CFG_DIRECTION: dir_reg  = cfg_data[0];
          default: ;
        endcase
        cfg_writes++;
      end
      if ((out_valid && !out_stall) || (in_valid && !in_stall) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("FAIL matrix_vector_product");
      $finish;
    end
  end

  // input driver: a new item only once the previous one has transferred
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (pending_items.size() > 0 && !roll(sender_idle_pct())) begin
        in_valid <= 1'b1;
        in_data  <= pending_items.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output stall: random, or a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_seen != hold_requests) begin
      hold_seen <= hold_requests;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= roll(receiver_idle_pct());
    end
  end

  function automatic logic signed [15:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return -16'sd1;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_item(logic [1:0] kind, int r, int c, int vi, logic signed [15:0] value);
    in_item_t it;
    it.kind         = kind;
    it.row_index    = 4'(r);
    it.col_index    = 4'(c);
    it.vector_index = 4'(vi);
    it.value        = value;
    pending_items = {pending_items, it};
    if (kind == KIND_MATRIX) matrix_written[r][c] = 1'b1;
    if (kind == KIND_VECTOR) vector_written[vi] = 1'b1;
    if (kind != KIND_NONE) items_queued++;
  endtask

  task automatic queue_matrix(int r, int c, logic signed [15:0] value);
    queue_item(KIND_MATRIX, r, c, $urandom_range(0, 15), value);
  endtask

  task automatic queue_vector(int vi, logic signed [15:0] value);
    queue_item(KIND_VECTOR, $urandom_range(0, 15), $urandom_range(0, 15), vi, value);
  endtask

  task automatic queue_compute();
    queue_item(KIND_COMPUTE, $urandom_range(0, 15), $urandom_range(0, 15),
               $urandom_range(0, 15), pick_value());
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid || expected_sums.size() != 0)
      @(posedge clk_i);
    // loads leave no result behind, give them time to land
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_shape(logic [4:0] rows, logic [4:0] cols, logic [4:0] dir_raw);
    wait_idle();
    write_register(CFG_ROW_COUNT, rows);
    write_register(CFG_COL_COUNT, cols);
    write_register(CFG_DIRECTION, dir_raw);
    gen_rows = clamp_dim(rows);
    gen_cols = clamp_dim(cols);
    gen_dir  = dir_raw[0];
  endtask

  // every entry the next compute reads must hold data
  task automatic fill_missing();
    int vec_len;
    vec_len = gen_dir ? gen_rows : gen_cols;
    for (int r = 0; r < gen_rows; r++)
      for (int c = 0; c < gen_cols; c++)
        if (!matrix_written[r][c]) queue_matrix(r, c, pick_value());
    for (int j = 0; j < vec_len; j++)
      if (!vector_written[j]) queue_vector(j, pick_value());
  endtask

  task automatic queue_random_loads(int count);
    int vec_len;
    vec_len = gen_dir ? gen_rows : gen_cols;
    repeat (count) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: queue_matrix($urandom_range(0, gen_rows - 1),
                                 $urandom_range(0, gen_cols - 1), pick_value());
        4, 5, 6: queue_vector($urandom_range(0, vec_len - 1), pick_value());
        7: queue_matrix($urandom_range(0, 15), $urandom_range(0, 15), pick_value());
        8: queue_vector($urandom_range(0, 15), pick_value());
        default: queue_item(KIND_NONE, $urandom_range(0, 15), $urandom_range(0, 15),
                            $urandom_range(0, 15), pick_value());
      endcase
    end
  endtask

  function automatic logic [4:0] pick_count(bit allow_big);
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 5'd0;
    if (allow_big && pick == 1) return 5'd16;
    if (allow_big && pick == 2) return 5'($urandom_range(17, 31));
    if (allow_big && pick == 3) return 5'($urandom_range(6, 15));
    return 5'($urandom_range(1, 5));
  endfunction

  initial begin
    int phase_no;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // one-element dot products at the value extremes
    queue_matrix(0, 0, 16'sh8000);
    queue_vector(0, 16'sh8000);
    queue_compute();
    queue_vector(0, 16'sh7fff);
    queue_compute();
    queue_matrix(0, 0, 16'sh7fff);
    queue_compute();
    queue_vector(0, -16'sd1);
    queue_matrix(0, 0, -16'sd1);
    queue_item(KIND_NONE, 15, 15, 15, 16'sh7fff);
    queue_compute();
    // writes outside the active shape must not disturb it
    queue_matrix(15, 15, 16'sh8000);
    queue_vector(15, 16'sh7fff);
    queue_compute();

    // two rows, one column, in both directions
    set_shape(5'd2, 5'd1, 5'd1);
    queue_matrix(1, 0, 16'sh7fff);
    queue_vector(1, 16'sh8000);
    queue_compute();
    set_shape(5'd2, 5'd1, 5'd0);
    queue_compute();
    wait_idle();
    write_register(CFG_UNUSED, 5'h1f);
    queue_compute();

    phase_no = 0;
    while (items_queued < ITEM_TARGET) begin
      if (phase_no == 3) begin
        // largest shape, all entries at the negative extreme, then mixed signs
        set_shape(5'd16, 5'd31, 5'd0);
        for (int r = 0; r < MAX_DIM; r++)
          for (int c = 0; c < MAX_DIM; c++)
            queue_matrix(r, c, 16'sh8000);
        for (int j = 0; j < MAX_DIM; j++) queue_vector(j, 16'sh8000);
        queue_compute();
        for (int j = 0; j < MAX_DIM; j++) queue_vector(j, 16'sh7fff);
        queue_compute();
        set_shape(5'd31, 5'd16, 5'b10101);
        queue_compute();
      end else if (phase_no == 4) begin
        // hold the output back while computes keep arriving
        set_shape(5'($urandom_range(8, 16)), 5'($urandom_range(1, 4)), 5'd0);
        hold_requests++;
        repeat (4) begin
          queue_random_loads($urandom_range(0, 3));
          queue_compute();
        end
      end else begin
        set_shape(pick_count(phase_no > 3), pick_count(phase_no > 3),
                  5'($urandom_range(0, 31)));
        repeat ($urandom_range(1, 3)) begin
          queue_random_loads($urandom_range(0, 6));
          fill_missing();
          queue_compute();
          if (roll(25)) queue_compute();
        end
      end
      phase_no++;
    end

    wait_idle();
    repeat (END_CYCLES) @(posedge clk_i);
    $display("run covered %0d items (%0d computes) across %0d shape phases",
             items_accepted, computes_seen, phase_no);
    $display("%0d register writes, checked %0d sums, %0d mismatches",
             cfg_writes, sums_checked, mismatches);
    if (mismatches == 0 && expected_sums.size() == 0)
      $display("PASS matrix_vector_product");
    else
      $display("FAIL matrix_vector_product");
    $finish;
  end

endmodule
